// ===== rtl/gsm_pkg.sv =====
// shared types and constants for the generational slot map
// no dependencies; imported by generational_slot_map and gsm_engine

package gsm_pkg;

  // fixed field widths of the stream payload
  localparam int unsigned CmdW      = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned IdxFieldW = 8;
  localparam int unsigned GenW      = 32;
  localparam int unsigned ValFieldW = 64;
  localparam int unsigned InDataW   = ValFieldW + IdxFieldW + GenW;
  localparam int unsigned OutDataW  = IdxFieldW + GenW + ValFieldW;

  typedef enum logic [CmdW-1:0] {
    CMD_RETAIN  = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // where a retain takes its slot from
  typedef enum logic [1:0] {
    SRC_FREE  = 2'd0,
    SRC_FRESH = 2'd1,
    SRC_FULL  = 2'd2
  } src_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    status_e                status;
    logic [IdxFieldW-1:0]   new_index;
    logic [GenW-1:0]        new_generation;
    logic [ValFieldW-1:0]   read_value;
  } result_t;

endpackage

// ===== rtl/generational_slot_map.sv =====
// generational slot map: handle table with generation-checked tokens
// result path: the sequencer's execute state, then the output register onto m_axis
// commands are taken one at a time: the next waits for the slot read, then write-back on the
//   single-port-per-direction slot memory; a stalled result holds the sequencer
// reset: free list empty and no slot handed out; the slot memory is not cleared
// files: gsm_pkg, gsm_slot_ram, gsm_engine

module generational_slot_map #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gsm_pkg::InDataW-1:0]    s_axis_tdata,  // store_value, token_index, token_generation
  input  logic [gsm_pkg::CmdW-1:0]       s_axis_tuser,  // cmd
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gsm_pkg::OutDataW-1:0]   m_axis_tdata,  // new_index, new_generation, read_value
  output logic [gsm_pkg::StatusW-1:0]    m_axis_tuser   // status
);
  import gsm_pkg::*;

  // slot index width, and count width that also holds the empty-list sentinel
  localparam int unsigned IdxW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW   = $clog2(SLOTS + 1);
  localparam int unsigned EntryW = VALUE_BITS + GenW + 1 + CntW;

  logic              res_valid, res_ready;
  result_t           res;
  logic [IdxW-1:0]   rd_addr, wr_addr;
  logic [EntryW-1:0] rd_data, wr_data;
  logic              wr_en;

  // output register between the sequencer and the result stream
  logic              out_valid_q;
  result_t           out_q;

  // unpack command payload, lowest field first
  logic [ValFieldW-1:0] in_value;
  logic [IdxFieldW-1:0] in_idx;
  logic [GenW-1:0]      in_gen;

  assign in_value = s_axis_tdata[ValFieldW-1:0];
  assign in_idx   = s_axis_tdata[ValFieldW +: IdxFieldW];
  assign in_gen   = s_axis_tdata[ValFieldW + IdxFieldW +: GenW];

  gsm_slot_ram #(
    .Width (EntryW),
    .Depth (SLOTS),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  gsm_engine #(
    .Slots     (SLOTS),
    .ValueBits (VALUE_BITS),
    .IdxW      (IdxW),
    .CntW      (CntW),
    .EntryW    (EntryW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .value_i     (in_value),
    .idx_i       (in_idx),
    .gen_i       (in_gen),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // the register takes a new result when empty or when its content leaves now
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // pack result payload, lowest field first
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.read_value, out_q.new_generation, out_q.new_index};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("pending result transfer changed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_ready)
    else $error("result produced while output register blocked");

  a_single_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command taken while one is in progress");

endmodule

// ===== rtl/gsm_slot_ram.sv =====
// slot table storage: one write port, one read port, registered read data
// generic, no package dependencies

module gsm_slot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = 2
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== rtl/gsm_engine.sv =====
// command sequencer: reads a slot entry, checks the token, writes back any entry it changes
// uses gsm_pkg; drives the read and write ports of gsm_slot_ram

module gsm_engine #(
  parameter int unsigned Slots     = 256,
  parameter int unsigned ValueBits = 64,
  parameter int unsigned IdxW      = 8,
  parameter int unsigned CntW      = 9,
  parameter int unsigned EntryW    = 64 + 32 + 1 + 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gsm_pkg::CmdW-1:0]      cmd_i,
  input  logic [gsm_pkg::ValFieldW-1:0] value_i,
  input  logic [gsm_pkg::IdxFieldW-1:0] idx_i,
  input  logic [gsm_pkg::GenW-1:0]      gen_i,
  input  logic                      res_ready_i,
  output logic                      res_valid_o,
  output gsm_pkg::result_t          res_o,
  output logic [IdxW-1:0]           rd_addr_o,
  input  logic [EntryW-1:0]         rd_data_i,
  output logic                      wr_en_o,
  output logic [IdxW-1:0]           wr_addr_o,
  output logic [EntryW-1:0]         wr_data_o
);
  import gsm_pkg::*;

  // wide enough for the token index field and the slot index (IxW) or the slot count (CmpW)
  localparam int unsigned IxW = (IdxW > IdxFieldW) ? IdxW : IdxFieldW;
  localparam int unsigned CmpW = (CntW > IdxFieldW) ? CntW : IdxFieldW;
  localparam logic [CntW-1:0] SlotsC = CntW'(Slots);

  // entry layout from bit 0: value, generation, in-use, next-free link
  localparam int unsigned GenLo  = ValueBits;
  localparam int unsigned UseBit = ValueBits + GenW;
  localparam int unsigned NxtLo  = UseBit + 1;

  state_e                state_q, state_d;
  logic [CntW-1:0]       head_q, head_d;
  logic [CntW-1:0]       used_q, used_d;
  logic [CmdW-1:0]       cmd_q;
  src_e                  src_q, src_sel;
  logic [ValueBits-1:0]  val_q;
  logic [IdxFieldW-1:0]  idx_q;
  logic [GenW-1:0]       gen_q;
  logic [IdxW-1:0]       addr_q, addr_sel;
  logic [IxW-1:0]        idx_wide;
  logic                  accept, commit;

  logic [ValueBits-1:0]  rd_val;
  logic [GenW-1:0]       rd_gen;
  logic                  rd_use;
  logic [CntW-1:0]       rd_next;
  logic                  tok_ok;
  logic [GenW-1:0]       gen_inc;
  logic [IdxW-1:0]       slot;
  logic [IxW-1:0]        slot_wide;
  logic                  wr_req;
  result_t               res;

  assign rd_val  = rd_data_i[ValueBits-1:0];
  assign rd_gen  = rd_data_i[GenLo +: GenW];
  assign rd_use  = rd_data_i[UseBit];
  assign rd_next = rd_data_i[NxtLo +: CntW];

  // slot selection at accept time
  assign idx_wide = IxW'(idx_i);
  always_comb begin
    if (head_q < SlotsC) begin
      src_sel = SRC_FREE;
    end else if (used_q < SlotsC) begin
      src_sel = SRC_FRESH;
    end else begin
      src_sel = SRC_FULL;
    end
  end

  always_comb begin
    if (cmd_i == CMD_RETAIN) begin
      addr_sel = (src_sel == SRC_FREE) ? head_q[IdxW-1:0] : used_q[IdxW-1:0];
    end else begin
      addr_sel = idx_wide[IdxW-1:0];
    end
  end

  // the read port follows the incoming item while idle and then holds the
  // latched address, so the read data stays valid while the result stalls
  assign rd_addr_o = (state_q == S_IDLE) ? addr_sel : addr_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_EXEC: commit = res_ready_i;
      default: begin
        in_ready_o = 1'b0;
        commit     = 1'b0;
      end
    endcase
  end

  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = commit;
  assign wr_en_o     = commit && wr_req;
  assign res_o       = res;

  // token check against the entry just read
  assign tok_ok = !(idx_q == '0 && gen_q == '0)
                && (CmpW'(idx_q) < CmpW'(used_q))
                && rd_use
                && (rd_gen == gen_q);

  assign gen_inc = rd_gen + GenW'(1);

  // datapath: result and write-back entry
  always_comb begin
    res            = '0;
    res.status     = STAT_BAD;
    wr_req         = 1'b0;
    wr_addr_o      = addr_q;
    wr_data_o      = '0;
    head_d         = head_q;
    used_d         = used_q;
    slot           = addr_q;
    slot_wide      = IxW'(slot);
    unique case (cmd_q)
      CMD_RETAIN: begin
        unique case (src_q)
          SRC_FREE: begin
            wr_req    = 1'b1;
            head_d    = rd_next;
            wr_data_o = {rd_next, 1'b1, gen_inc, val_q};
            res.status         = STAT_OK;
            res.new_index      = slot_wide[IdxFieldW-1:0];
            res.new_generation = gen_inc;
          end
          SRC_FRESH: begin
            // a never-used slot starts at generation zero, so it issues one
            wr_req    = 1'b1;
            used_d    = used_q + CntW'(1);
            wr_data_o = {SlotsC, 1'b1, GenW'(1), val_q};
            res.status         = STAT_OK;
            res.new_index      = slot_wide[IdxFieldW-1:0];
            res.new_generation = GenW'(1);
          end
          default: res.status = STAT_FULL;
        endcase
      end
      CMD_LOOKUP: begin
        if (tok_ok) begin
          res.status     = STAT_OK;
          res.read_value = ValFieldW'(rd_val);
        end
      end
      CMD_RELEASE: begin
        if (tok_ok) begin
          wr_req     = 1'b1;
          wr_data_o  = {head_q, 1'b0, rd_gen, {ValueBits{1'b0}}};
          head_d     = CntW'(idx_q);
          res.status = STAT_OK;
        end
      end
      default: res.status = STAT_BAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= SlotsC;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        head_q <= head_d;
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      src_q  <= src_sel;
      val_q  <= value_i[ValueBits-1:0];
      idx_q  <= idx_i;
      gen_q  <= gen_i;
      addr_q <= addr_sel;
    end
  end

  a_wr_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == S_EXEC))
    else $error("slot write outside of execute state");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SlotsC)
    else $error("used count beyond table size");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == SlotsC) || (head_q < used_q))
    else $error("free list head names a slot never handed out");

  a_commit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after a result");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC) && $stable(used_q) && $stable(head_q))
    else $error("accepted command did not move to execute");

endmodule

// ===== verif/tb_generational_slot_map.sv =====
// testbench for generational_slot_map: directed and random command streams, each result
// checked against an in-bench model of the handle table
// depends on rtl/gsm_pkg.sv and rtl/generational_slot_map.sv
`timescale 1ns / 1ps

module tb_generational_slot_map;
  import gsm_pkg::*;

  localparam logic [8:0]  SlotCount  = 9'd256;
  localparam logic [1:0]  CmdUnknown = 2'd3;   // not a defined command, must answer bad status
  localparam int unsigned StallLimit = 2000;   // cycles with no transfer on either side
  localparam int unsigned MaxReports = 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;   // store_value, token_index, token_generation
  logic [CmdW-1:0]       s_axis_tuser;   // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;   // new_index, new_generation, read_value
  logic [StatusW-1:0]    m_axis_tuser;   // status

  generational_slot_map dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the handle table
  bit   [63:0] slot_val  [256];
  bit   [31:0] slot_gen  [256];
  bit          slot_live [256];
  bit   [8:0]  slot_link [256];
  logic [8:0]  free_top     = SlotCount;   // SlotCount means the free list is empty
  logic [8:0]  slots_issued = '0;          // slots ever handed out
  logic [7:0]  last_index;
  logic [31:0] last_gen;

  result_t pending_results[$];

  bit gaps_on = 1'b1;
  int mismatch_count  = 0;
  int results_seen    = 0;
  int cmds_sent       = 0;
  int retains_ok      = 0;
  int full_answers    = 0;
  int lookup_hits     = 0;
  int releases_ok     = 0;
  int rejected        = 0;
  int unsigned quiet_cycles = 0;

  // advance the shadow table by one command and return the answer it must give
  function automatic result_t slot_map_step(logic [1:0] op, logic [63:0] value,
                                            logic [7:0] index, logic [31:0] gen);
    result_t    r;
    logic [8:0] slot;
    bit         have_slot;
    bit         token_ok;
    r         = '0;
    r.status  = STAT_BAD;
    have_slot = 1'b0;
    // the none token never names a slot, even if slot 0 has wrapped to generation 0
    token_ok  = !(index == 8'd0 && gen == 32'd0) && ({1'b0, index} < slots_issued) &&
                slot_live[index] && (slot_gen[index] == gen);
    if (op == CMD_RETAIN) begin
      if (free_top != SlotCount) begin
        slot      = free_top;
        free_top  = slot_link[slot[7:0]];
        have_slot = 1'b1;
      end else if (slots_issued != SlotCount) begin
        slot               = slots_issued;
        slots_issued       = slots_issued + 9'd1;
        slot_gen[slot[7:0]] = '0;
        have_slot          = 1'b1;
      end else begin
        r.status = STAT_FULL;
        full_answers++;
      end
      if (have_slot) begin
        slot_val[slot[7:0]]  = value;
        slot_live[slot[7:0]] = 1'b1;
        slot_gen[slot[7:0]]  = slot_gen[slot[7:0]] + 32'd1;   // wraps past all ones
        r.status         = STAT_OK;
        r.new_index      = slot[7:0];
        r.new_generation = slot_gen[slot[7:0]];
        last_index       = slot[7:0];
        last_gen         = slot_gen[slot[7:0]];
        retains_ok++;
      end
    end else if (op == CMD_LOOKUP && token_ok) begin
      r.status     = STAT_OK;
      r.read_value = slot_val[index];
      lookup_hits++;
    end else if (op == CMD_RELEASE && token_ok) begin
      slot_val[index]  = '0;
      slot_live[index] = 1'b0;
      slot_link[index] = free_top;
      free_top         = {1'b0, index};
      r.status         = STAT_OK;
      releases_ok++;
    end else if (op != CMD_RETAIN) begin
      rejected++;
    end
    return r;
  endfunction

  // one command transfer, with an optional idle burst in front of it
  task automatic send_cmd(input logic [1:0] op, input logic [63:0] value,
                          input logic [7:0] index, input logic [31:0] gen);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gen, index, value};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(slot_map_step(op, value, index, gen));
    cmds_sent++;
  endtask

  // hold off the command side until every answer is back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // mostly well-formed tokens taken from the shadow table, some corrupted, some noise
  task automatic send_random_op();
    logic [1:0]  op;
    logic [63:0] value;
    logic [7:0]  index;
    logic [31:0] gen;
    int          pick;
    pick  = $urandom_range(0, 99);
    value = {$urandom, $urandom};
    index = 8'($urandom);
    gen   = $urandom;
    if (pick < 38) begin
      op = CMD_RETAIN;
    end else if (pick < 88) begin
      op = (pick < 68) ? CMD_LOOKUP : CMD_RELEASE;
      if (slots_issued != 0) begin
        index = 8'($urandom_range(0, slots_issued - 1));
        gen   = slot_gen[index];
        if ($urandom_range(0, 7) == 0) gen = gen ^ (32'd1 << $urandom_range(0, 31));
      end
    end else begin
      op = 2'($urandom_range(0, 3));   // raw noise, unknown command included
    end
    send_cmd(op, value, index, gen);
  endtask

  // reset corner cases, value extremes, stale and double release, slot reuse
  task automatic test_directed();
    send_cmd(CMD_LOOKUP,  64'd0, 8'd0, 32'd0);                    // none token
    send_cmd(CMD_RELEASE, 64'd0, 8'd0, 32'd0);
    send_cmd(CMD_LOOKUP,  '1,    8'hff, 32'hffff_ffff);           // nothing handed out yet
    send_cmd(CmdUnknown,  '1,    8'hff, 32'hffff_ffff);
    send_cmd(CMD_RETAIN,  64'd0, 8'd0, 32'd0);
    send_cmd(CMD_RETAIN,  '1,    8'hff, 32'hffff_ffff);
    send_cmd(CMD_RETAIN,  64'h8000_0000_0000_0001, 8'd0, 32'd0);
    send_cmd(CMD_LOOKUP,  64'd0, 8'd0, 32'd1);
    send_cmd(CMD_LOOKUP,  64'd0, 8'd1, 32'd1);
    send_cmd(CMD_LOOKUP,  64'd0, 8'd0, 32'd0);                    // none token on a live slot
    send_cmd(CMD_LOOKUP,  64'd0, 8'd1, 32'hffff_ffff);            // wrong generation
    send_cmd(CMD_LOOKUP,  64'd0, 8'd3, 32'd1);                    // index past the high mark
    send_cmd(CMD_RELEASE, 64'd0, 8'd1, 32'd1);
    send_cmd(CMD_LOOKUP,  64'd0, 8'd1, 32'd1);                    // stale after release
    send_cmd(CMD_RELEASE, 64'd0, 8'd1, 32'd1);                    // double release
    send_cmd(CMD_RELEASE, 64'd0, 8'd0, 32'd1);
    send_cmd(CMD_RETAIN,  64'h0123_4567_89ab_cdef, 8'd0, 32'd0);  // reuses slot 0
    send_cmd(CMD_RETAIN,  64'hfedc_ba98_7654_3210, 8'd0, 32'd0);  // reuses slot 1
    send_cmd(CMD_RETAIN,  64'h5555_aaaa_5555_aaaa, 8'd0, 32'd0);  // fresh slot 3
    send_cmd(CMD_LOOKUP,  64'd0, 8'd0, 32'd2);
    send_cmd(CMD_LOOKUP,  64'd0, 8'd1, 32'd1);
    send_cmd(CmdUnknown,  64'd0, 8'd0, 32'd0);
    send_cmd(CMD_RELEASE, 64'd0, 8'd2, 32'd1);
    send_cmd(CMD_LOOKUP,  64'd0, 8'd2, 32'd1);
  endtask

  task automatic test_random_traffic();
    int k;
    for (k = 0; k < 250; k++) begin
      send_random_op();
      if (k == 125) wait_for_results();
    end
  endtask

  // fill every slot, hit the full answer, then free a quarter and refill from the free list
  task automatic test_table_full();
    int k;
    wait_for_results();
    while (!(free_top == SlotCount && slots_issued == SlotCount))
      send_cmd(CMD_RETAIN, {$urandom, $urandom}, 8'($urandom), $urandom);
    repeat (4) send_cmd(CMD_RETAIN, {$urandom, $urandom}, 8'($urandom), $urandom);
    send_cmd(CMD_LOOKUP, 64'd0, 8'hff, slot_gen[255]);
    for (k = 0; k < 256; k += 4)
      if (slot_live[k]) send_cmd(CMD_RELEASE, {$urandom, $urandom}, 8'(k), slot_gen[k]);
    for (k = 0; k < 20; k++) begin
      send_cmd(CMD_RETAIN, {$urandom, $urandom}, 8'($urandom), $urandom);
      send_cmd(CMD_LOOKUP, 64'd0, last_index, last_gen);
    end
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_steady_stream();
    int k;
    gaps_on = 1'b0;
    for (k = 0; k < 80; k++) send_random_op();
  endtask

  // result side: ready bursts broken by random low stretches while gaps are on
  initial begin : result_sink
    int run;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        run = $urandom_range(1, 12);
      end else begin
        m_axis_tready <= 1'b1;
        run = $urandom_range(1, 24);
      end
      repeat (run) @(posedge clk_i);
    end
  end

  // compare each result transfer against the oldest pending answer
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status         = status_e'(m_axis_tuser);
      got.new_index      = m_axis_tdata[7:0];
      got.new_generation = m_axis_tdata[39:8];
      got.read_value     = m_axis_tdata[103:40];
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: unexpected result status %0d index %0d gen %h value %h", $realtime,
                   got.status, got.new_index, got.new_generation, got.read_value);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.new_index !== want.new_index ||
            got.new_generation !== want.new_generation || got.read_value !== want.read_value) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("%0t: result %0d mismatch (expected / actual)", $realtime, results_seen);
            $display("  status %0d / %0d  index %0d / %0d", want.status, got.status,
                     want.new_index, got.new_index);
            $display("  gen %h / %h  value %h / %h", want.new_generation, got.new_generation,
                     want.read_value, got.read_value);
          end
        end
      end
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results pending", $realtime, StallLimit,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : run_tests
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_table_full();
    test_steady_stream();
    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("ran %0d commands: %0d retains, %0d table-full, %0d lookup hits, %0d releases",
             cmds_sent, retains_ok, full_answers, lookup_hits, releases_ok);
    $display("%0d rejected tokens or unknown commands, %0d results checked, %0d mismatches",
             rejected, results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
